// File: hw/rtl/arm64_address_xref_scanner_assert.svh
// Assertion macros for the scanner's RTL; only axs_back.sv includes them.
// Each macro samples on the rising edge of clk and is idle while arst_n is low.
`ifndef ARM64_ADDRESS_XREF_SCANNER_ASSERT_SVH
`define ARM64_ADDRESS_XREF_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AXS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AXS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/axs_pkg.sv
package axs_pkg;

	// Tracked register file geometry.
	localparam int NUM_TRACKED_REGS = 32;
	localparam int REG_AW = $clog2(NUM_TRACKED_REGS);

	// Depth of the queue between the decoder and the execution side.
	localparam int QUEUE_DEPTH = 4;

	// What the execution side does with a decoded word.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SET  = 2'd1;
	localparam logic [1:0] KIND_ADD  = 2'd2;

	// Opcode masks and match values.
	localparam logic [31:0] ADRP_MASK    = 32'h9F00_0000;
	localparam logic [31:0] ADRP_MATCH   = 32'h9000_0000;
	localparam logic [31:0] ADD_MASK     = 32'hFF00_0000;
	localparam logic [31:0] ADD_MATCH    = 32'h9100_0000;
	localparam logic [31:0] LDR_MASK     = 32'hF9C0_0000;
	localparam logic [31:0] LDR_MATCH    = 32'hF940_0000;
	localparam logic [31:0] ADR_MASK     = 32'h9F00_0000;
	localparam logic [31:0] ADR_MATCH    = 32'h1000_0000;
	localparam logic [31:0] LIT_MASK     = 32'hFF00_0000;
	localparam logic [31:0] LIT_MATCH    = 32'h5800_0000;
	localparam logic [31:0] LIT_IMM_MASK = 32'h00FF_FFE0;
	localparam logic [63:0] PAGE_MASK    = 64'h0000_0000_0000_0FFF;

	// Configuration register indexes.
	localparam logic REG_TARGET = 1'b0;

	// One decoded request as it travels from the decoder to execution.
	typedef struct packed {
		logic [1:0]        kind;
		logic [REG_AW-1:0] rd;
		logic [REG_AW-1:0] rn;
		logic [63:0]       val;
		logic [31:0]       off;
		logic              first;
		logic              last;
	} dec_t;

endpackage

// File: hw/rtl/axs_front.sv
module axs_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instr_word,
	input  logic [31:0]        instr_offset,
	input  logic               first_of_scan,
	input  logic               last_of_scan,
	output logic               push_valid,
	input  logic               push_ready,
	output axs_pkg::dec_t      push_item
);
	import axs_pkg::*;

	logic [63:0] off64;
	logic [20:0] imm21;
	logic [63:0] imm21_sx;
	logic [11:0] imm12;
	logic [31:0] w;

	// The queue alone decides whether a request can be taken.
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	assign w        = instr_word;
	assign off64    = {32'd0, instr_offset[31:2], 2'b00};
	assign imm21    = {w[23:5], w[30:29]};
	assign imm21_sx = {{43{imm21[20]}}, imm21};
	assign imm12    = w[21:10];

	// Classify the word and fold everything that does not need a register read.
	always_comb begin
		push_item.rd    = w[REG_AW-1:0];
		push_item.rn    = w[5 +: REG_AW];
		push_item.off   = {instr_offset[31:2], 2'b00};
		push_item.first = first_of_scan;
		push_item.last  = last_of_scan;
		push_item.kind  = KIND_NONE;
		push_item.val   = '0;
		if ((w & ADRP_MASK) == ADRP_MATCH) begin
			push_item.kind = KIND_SET;
			push_item.val  = (off64 & ~PAGE_MASK) + {imm21_sx[51:0], 12'd0};
		end else if ((w & ADD_MASK) == ADD_MATCH) begin
			push_item.kind = KIND_ADD;
			if (w[23:22] == 2'b01) begin
				push_item.val = {40'd0, imm12, 12'd0};
			end else begin
				push_item.val = {52'd0, imm12};
			end
		end else if ((w & LDR_MASK) == LDR_MATCH) begin
			push_item.kind = KIND_ADD;
			push_item.val  = {49'd0, imm12, 3'd0};
		end else if ((w & ADR_MASK) == ADR_MATCH) begin
			push_item.kind = KIND_SET;
			push_item.val  = off64 + imm21_sx;
		end else if ((w & LIT_MASK) == LIT_MATCH) begin
			push_item.kind = KIND_SET;
			push_item.val  = off64 + {32'd0, (w & LIT_IMM_MASK) >> 3};
		end
	end

endmodule

// File: hw/rtl/axs_queue.sv
module axs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  axs_pkg::dec_t push_item,
	output logic          pop_valid,
	input  logic          pop_ready,
	output axs_pkg::dec_t pop_item
);
	import axs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	dec_t          slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Request storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/axs_back.sv
`include "arm64_address_xref_scanner_assert.svh"

module axs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [63:0]   target_value,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  axs_pkg::dec_t pop_item,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          hit,
	output logic [31:0]   hit_offset
);
	import axs_pkg::*;

	logic [63:0]                 regs_mem [NUM_TRACKED_REGS];
	logic [NUM_TRACKED_REGS-1:0] valid_q;
	logic [REG_AW-1:0]           last_addr_q;
	logic [63:0]                 last_data_q;
	logic                        done_q;

	logic                        valid_s2;
	dec_t                        item_s2;
	logic [63:0]                 rdn_s2;
	logic [63:0]                 rdd_s2;

	logic                        out_valid_q;
	logic                        hit_q;
	logic [31:0]                 off_q;

	logic                        adv;
	logic                        out_free;
	logic                        b2_done;
	logic                        done_eff;
	logic                        active;
	logic [63:0]                 rn_val;
	logic [63:0]                 rd_val;
	logic [63:0]                 wr_val;
	logic [63:0]                 new_val;
	logic                        match;
	logic                        res;
	logic                        wr_en;
	logic [NUM_TRACKED_REGS-1:0] valid_nxt;

	// Stage two frees up when its request finishes; the output register may take a result.
	assign out_free  = !out_valid_q || out_ready;
	assign b2_done   = valid_s2 && (!res || out_free);
	assign pop_ready = !valid_s2 || b2_done;
	assign adv       = pop_valid && pop_ready;

	// Operand values: a new scan reads zero, an unwritten entry reads zero, and the
	// write made at the same edge as the read is taken from the bypass register.
	always_comb begin
		rn_val = '0;
		rd_val = '0;
		if (!item_s2.first) begin
			if (valid_q[item_s2.rn]) begin
				rn_val = (last_addr_q == item_s2.rn) ? last_data_q : rdn_s2;
			end
			if (valid_q[item_s2.rd]) begin
				rd_val = (last_addr_q == item_s2.rd) ? last_data_q : rdd_s2;
			end
		end
	end

	// Execute, then compare the destination register with the target.
	assign done_eff = item_s2.first ? 1'b0 : done_q;
	assign active   = !done_eff;
	assign wr_val   = (item_s2.kind == KIND_SET) ? item_s2.val : rn_val + item_s2.val;
	assign new_val  = (item_s2.kind != KIND_NONE) ? wr_val : rd_val;
	assign match    = (new_val == target_value);
	assign res      = active && (match || item_s2.last);
	assign wr_en    = b2_done && active && (item_s2.kind != KIND_NONE);

	always_comb begin
		valid_nxt = item_s2.first ? '0 : valid_q;
		if (wr_en) begin
			valid_nxt[item_s2.rd] = 1'b1;
		end
	end

	// Register file with two registered read ports, read as a request enters stage two.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs_mem[item_s2.rd] <= wr_val;
		end
		if (adv) begin
			rdn_s2 <= regs_mem[pop_item.rn];
			rdd_s2 <= regs_mem[pop_item.rd];
		end
	end

	// Bypass copy of the most recent write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_addr_q <= item_s2.rd;
			last_data_q <= wr_val;
		end
	end

	// Stage two request register.
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= pop_item;
		end
	end

	// Control state: stage occupancy, entry valid bits and the scan done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (b2_done) begin
				valid_s2 <= 1'b0;
			end
			if (b2_done) begin
				valid_q <= valid_nxt;
				done_q  <= res || done_eff;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (b2_done && res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b2_done && res) begin
			hit_q <= match;
			off_q <= match ? item_s2.off : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign hit_offset = off_q;

	`AXS_ASSERT_NEXT(a_done_after_result, b2_done && res, done_q, "scan not closed after result")
	`AXS_ASSERT_NEXT(a_first_clears, b2_done && item_s2.first, $countones(valid_q) <= 1, "stale regs after new scan")
	`AXS_ASSERT_NOW(a_miss_offset_zero, out_valid_q && !hit_q, off_q == '0, "miss with nonzero offset")

endmodule

// File: hw/rtl/arm64_address_xref_scanner.sv
// Scans a stream of ARM64 instruction words for the first one that forms the
// address in target_value, tracking ADRP, ADD immediate, LDR unsigned offset,
// ADR and LDR literal into 32 shadow registers. One request is taken per clock
// while the queue has room; a decoder fills a four-entry queue and the execution
// side drains it at one request per cycle unless a result waits on out_ready,
// reading the register file and bypassing the previous write, and a result (hit
// with its aligned offset, or a miss on the last word) is held in an output
// register. Each scan emits at most one result; words after it are dropped
// until first_of_scan is set. target_value is written over the APB port when
// paddr[3] is 0; the user must do so only while the block is idle (not enforced).
module arm64_address_xref_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr_word,
	input  logic [31:0] instr_offset,
	input  logic        first_of_scan,
	input  logic        last_of_scan,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [31:0] hit_offset,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import axs_pkg::*;

	logic [63:0] target_q;
	logic        push_valid;
	logic        push_ready;
	dec_t        push_item;
	logic        pop_valid;
	logic        pop_ready;
	dec_t        pop_item;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_TARGET) ? target_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[3] == REG_TARGET)) begin
			target_q <= pwdata;
		end
	end

	axs_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.instr_word    (instr_word),
		.instr_offset  (instr_offset),
		.first_of_scan (first_of_scan),
		.last_of_scan  (last_of_scan),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	axs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	axs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_value (target_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.hit_offset   (hit_offset)
	);

endmodule
